[hdl/modbus_sensor_reply_framer_assert.svh]
// assertion macros for the sensor reply framer
`ifndef MODBUS_SENSOR_REPLY_FRAMER_ASSERT_SVH
`define MODBUS_SENSOR_REPLY_FRAMER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define MSRF_ASSERT_IMPLY(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("framer check failed");

// next-cycle implication, checked out of reset
`define MSRF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("framer check failed");

`endif

[hdl/msrf_pkg.sv]
// types, constants and crc function for the sensor reply framer
`timescale 1ns / 1ps

package msrf_pkg;

    typedef enum logic [1:0]
    {
        KIND_OXYGEN = 2'd0,
        KIND_PH     = 2'd1,
        KIND_ORP    = 2'd2
    } sensor_kind_t;

    typedef enum logic [1:0]
    {
        CFG_OXYGEN_ADDR = 2'd0,
        CFG_PH_ADDR     = 2'd1,
        CFG_ORP_ADDR    = 2'd2
    } cfg_index_t;

    localparam int          COUNT_W         = 5;
    localparam int          FIRST_VALUE_POS = 3;
    localparam int          VALUE_BYTES     = 12;
    localparam int          VIDX_W          = 4;
    localparam logic [15:0] CRC_INIT        = 16'hFFFF;
    localparam logic [15:0] CRC_POLY        = 16'hA001;
    localparam logic [7:0]  OXYGEN_ADDR_RST = 8'h03;
    localparam logic [7:0]  PH_ADDR_RST     = 8'h04;
    localparam logic [7:0]  ORP_ADDR_RST    = 8'h05;
    localparam int          DATA_W          = 104;

    // one byte of the reflected crc-16, lsb first
    function automatic logic [15:0] crc16_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++)
        begin
            if (c[0])
                c = (c >> 1) ^ CRC_POLY;
            else
                c = c >> 1;
        end
        return c;
    endfunction

endpackage

[hdl/modbus_sensor_reply_framer.sv]
// sensor reply framer: address decode, crc-16 check and value capture
// the last byte passes through the input stage and then the result register to the master side
// throughput: one byte per cycle; the input stage and the result register each hold one entry
// a stalled result holds the input stage, so bytes pause only while the result waits
// reset: asynchronous, active low; clears counters, crc, valids, address registers to 3, 4, 5
`timescale 1ns / 1ps

module modbus_sensor_reply_framer
    import msrf_pkg::*;
#(
    parameter int OXYGEN_FRAME_LEN = 17,
    parameter int PH_FRAME_LEN     = 9,
    parameter int ORP_FRAME_LEN    = 9
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic [1:0]        cfg_addr,
    input  logic [7:0]        cfg_data,
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [7:0]        s_axis_tdata,   // [7:0] rx_byte
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [DATA_W-1:0] m_axis_tdata,   // [0] crc_ok, [32:1] value_one, [64:33] value_two,
                                              // [96:65] value_three, [97] send_request, rest 0
    output logic [1:0]        m_axis_tuser    // [1:0] sensor_kind
);

    localparam logic [5:0] OXY_LEN = 6'(OXYGEN_FRAME_LEN);
    localparam logic [5:0] PH_LEN  = 6'(PH_FRAME_LEN);
    localparam logic [5:0] ORP_LEN = 6'(ORP_FRAME_LEN);

    // configuration registers
    logic [7:0] oxygen_addr_reg;
    logic [7:0] ph_addr_reg;
    logic [7:0] orp_addr_reg;

    // input stage
    logic       in_valid_reg;
    logic [7:0] in_byte_reg;

    // frame state
    logic [COUNT_W-1:0] byte_count_reg, byte_count_next;
    logic [15:0]        crc_reg, crc_next;
    sensor_kind_t       kind_reg, kind_next;
    logic [7:0]         value_bytes_reg [VALUE_BYTES];
    logic [7:0]         crc_low_reg;

    // result register
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_kind_reg;
    logic               out_ok_reg;
    logic [31:0]        out_v1_reg, out_v2_reg, out_v3_reg;
    logic               out_send_reg;

    logic               proc_fire;
    logic               first_byte;
    logic               addr_hit;
    sensor_kind_t       kind_cur;
    logic [5:0]         len_cur;
    logic [5:0]         pos_ext;
    logic               is_crc_byte, is_crc_low, is_last;
    logic               cap_en;
    logic [VIDX_W-1:0]  cap_idx;
    logic               crc_ok;
    logic [31:0]        v1, v2, v3;

    assign proc_fire     = in_valid_reg && (!out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || proc_fire;
    assign first_byte    = (byte_count_reg == '0);
    assign pos_ext       = {1'b0, byte_count_reg};

    // address decode on the first byte, otherwise the latched kind
    always_comb
    begin
        kind_cur = kind_reg;
        addr_hit = 1'b1;
        if (first_byte)
        begin
            priority if (in_byte_reg == oxygen_addr_reg)
                kind_cur = KIND_OXYGEN;
            else if (in_byte_reg == ph_addr_reg)
                kind_cur = KIND_PH;
            else if (in_byte_reg == orp_addr_reg)
                kind_cur = KIND_ORP;
            else
                addr_hit = 1'b0;
        end
    end

    always_comb
    begin
        unique case (kind_cur)
            KIND_OXYGEN: len_cur = OXY_LEN;
            KIND_PH:     len_cur = PH_LEN;
            KIND_ORP:    len_cur = ORP_LEN;
            default:     len_cur = ORP_LEN;
        endcase
    end

    assign is_crc_byte = (pos_ext + 6'd2) < len_cur;
    assign is_crc_low  = (pos_ext + 6'd2) == len_cur;
    assign is_last     = !is_crc_byte && !is_crc_low;
    assign cap_en      = (byte_count_reg >= COUNT_W'(FIRST_VALUE_POS))
                      && (byte_count_reg < COUNT_W'(FIRST_VALUE_POS + VALUE_BYTES));
    assign cap_idx     = VIDX_W'(byte_count_reg - COUNT_W'(FIRST_VALUE_POS));

    assign crc_ok = ({in_byte_reg, crc_low_reg} == crc_reg);

    always_comb
    begin
        if (kind_reg == KIND_OXYGEN)
        begin
            v1 = {value_bytes_reg[0], value_bytes_reg[1], value_bytes_reg[2], value_bytes_reg[3]};
            v2 = {value_bytes_reg[4], value_bytes_reg[5], value_bytes_reg[6], value_bytes_reg[7]};
            v3 = {value_bytes_reg[8], value_bytes_reg[9], value_bytes_reg[10],
                  value_bytes_reg[11]};
        end
        else
        begin
            v1 = {16'h0000, value_bytes_reg[0], value_bytes_reg[1]};
            v2 = '0;
            v3 = '0;
        end
    end

    // frame state next values
    always_comb
    begin
        byte_count_next = byte_count_reg;
        crc_next        = crc_reg;
        kind_next       = kind_reg;
        if (proc_fire && addr_hit)
        begin
            kind_next = kind_cur;
            if (is_crc_byte)
            begin
                crc_next        = crc16_update(first_byte ? CRC_INIT : crc_reg, in_byte_reg);
                byte_count_next = byte_count_reg + 1'b1;
            end
            else if (is_crc_low)
            begin
                byte_count_next = byte_count_reg + 1'b1;
            end
            else
            begin
                byte_count_next = '0;
                crc_next        = CRC_INIT;
            end
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (proc_fire && addr_hit && is_last)
            out_valid_next = 1'b1;
        else if (m_axis_tready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            oxygen_addr_reg <= OXYGEN_ADDR_RST;
            ph_addr_reg     <= PH_ADDR_RST;
            orp_addr_reg    <= ORP_ADDR_RST;
            in_valid_reg    <= 1'b0;
            byte_count_reg  <= '0;
            crc_reg         <= CRC_INIT;
            kind_reg        <= KIND_OXYGEN;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_addr)
                    CFG_OXYGEN_ADDR: oxygen_addr_reg <= cfg_data;
                    CFG_PH_ADDR:     ph_addr_reg     <= cfg_data;
                    CFG_ORP_ADDR:    orp_addr_reg    <= cfg_data;
                    default:         ;
                endcase
            end
            if (s_axis_tready)
                in_valid_reg <= s_axis_tvalid;
            byte_count_reg <= byte_count_next;
            crc_reg        <= crc_next;
            kind_reg       <= kind_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_axis_tready && s_axis_tvalid)
            in_byte_reg <= s_axis_tdata;
        if (proc_fire && addr_hit)
        begin
            if (cap_en)
                value_bytes_reg[cap_idx] <= in_byte_reg;
            if (is_crc_low)
                crc_low_reg <= in_byte_reg;
            if (is_last)
            begin
                out_kind_reg <= kind_reg;
                out_ok_reg   <= crc_ok;
                out_v1_reg   <= v1;
                out_v2_reg   <= v2;
                out_v3_reg   <= v3;
                out_send_reg <= crc_ok && (kind_reg == KIND_ORP);
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_kind_reg;
    assign m_axis_tdata  = {6'b000000, out_send_reg, out_v3_reg, out_v2_reg, out_v1_reg,
                            out_ok_reg};

`include "modbus_sensor_reply_framer_assert.svh"

    `MSRF_ASSERT_IMPLY(a_send_only_good_orp, m_axis_tvalid && out_send_reg,
        out_ok_reg && (out_kind_reg == KIND_ORP))
    `MSRF_ASSERT_IMPLY(a_count_below_len, byte_count_reg != '0,
        pos_ext < len_cur)
    `MSRF_ASSERT_NEXT(a_unknown_addr_dropped, proc_fire && first_byte && !addr_hit,
        byte_count_reg == '0)

endmodule
